// ===== rtl/core/freq_to_pressure_interpolator_defines.svh =====
// Assertion macros for the RTL file that checks its own behavior.
// Every macro samples on clk and is disabled while rst is high.
`ifndef FREQ_TO_PRESSURE_INTERPOLATOR_DEFINES_SVH
`define FREQ_TO_PRESSURE_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FTP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FTP_ASSERT(lbl, prop, msg)
`define FTP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/ftp_pkg.sv =====
`timescale 1ns / 1ps
package ftp_pkg;

  localparam int TABLE_ENTRIES = 231;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int COUNT_W       = 20;
  localparam int SCALED_W      = 19;
  localparam int FREQ_W        = 15;
  localparam int PRESS_W       = 17;
  localparam int DIV_STEPS     = PRESS_W;

  // count * 4 / 10 == (2 * count) / 5, done as a multiply by ceil(2^23 / 5)
  localparam int MUL_W       = COUNT_W + 1;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int RECIP_SHIFT = 23;
  localparam logic [MUL_W-1:0] RECIP_MUL = MUL_W'((2 ** RECIP_SHIFT + 4) / 5);

  localparam int GROUP_SIZE  = 16;
  localparam int LOC_W       = $clog2(GROUP_SIZE);
  localparam int NUM_GROUPS  = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [PRESS_W-1:0] OVERLOAD_CODE = 17'h1FFFF;

  localparam logic [FREQ_W-1:0] FREQ_ROM [0:TABLE_ENTRIES-1] = '{
    15'd255, 15'd417, 15'd660, 15'd856, 15'd1064, 15'd1205, 15'd1415, 15'd1634, 15'd1831,
    15'd2039, 15'd2127, 15'd2215, 15'd2369, 15'd2457, 15'd2580, 15'd2658, 15'd2769,
    15'd2812, 15'd2932, 15'd3077, 15'd3148, 15'd3234, 15'd3363, 15'd3432, 15'd3583,
    15'd3615, 15'd3770, 15'd3814, 15'd3890, 15'd3945, 15'd4035, 15'd4135, 15'd4178,
    15'd4224, 15'd4302, 15'd4354, 15'd4430, 15'd4500, 15'd4610, 15'd4653, 15'd4718,
    15'd4787, 15'd4843, 15'd4923, 15'd4965, 15'd5021, 15'd5065, 15'd5126, 15'd5200,
    15'd5211, 15'd5308, 15'd5352, 15'd5418, 15'd5452, 15'd5541, 15'd5547, 15'd5628,
    15'd5673, 15'd5716, 15'd5771, 15'd5794, 15'd5828, 15'd5840, 15'd5904, 15'd5971,
    15'd6017, 15'd6042, 15'd6068, 15'd6092, 15'd6115, 15'd6182, 15'd6213, 15'd6246,
    15'd6266, 15'd6300, 15'd6400, 15'd6432, 15'd6457, 15'd6490, 15'd6509, 15'd6536,
    15'd6616, 15'd6634, 15'd6654, 15'd6706, 15'd6732, 15'd6761, 15'd6789, 15'd6817,
    15'd6860, 15'd6883, 15'd6904, 15'd6948, 15'd6981, 15'd6994, 15'd7037, 15'd7058,
    15'd7067, 15'd7085, 15'd7147, 15'd7352, 15'd7644, 15'd7930, 15'd8162, 15'd8316,
    15'd8571, 15'd8754, 15'd9152, 15'd9154, 15'd9401, 15'd9558, 15'd9601, 15'd9742,
    15'd10030, 15'd10129, 15'd10196, 15'd10284, 15'd10362, 15'd10400, 15'd10560,
    15'd10650, 15'd10720, 15'd10800, 15'd10890, 15'd10900, 15'd11030, 15'd11070,
    15'd11120, 15'd11220, 15'd11290, 15'd11370, 15'd11410, 15'd11480, 15'd11580,
    15'd11620, 15'd11670, 15'd11730, 15'd11750, 15'd11820, 15'd11870, 15'd11990,
    15'd12070, 15'd12090, 15'd12120, 15'd12150, 15'd12184, 15'd12251, 15'd12294,
    15'd12328, 15'd12383, 15'd12439, 15'd12481, 15'd12590, 15'd12661, 15'd12667,
    15'd12720, 15'd12768, 15'd12837, 15'd12918, 15'd12940, 15'd12973, 15'd13030,
    15'd13072, 15'd13104, 15'd13129, 15'd13141, 15'd13183, 15'd13216, 15'd13240,
    15'd13264, 15'd13294, 15'd13331, 15'd13354, 15'd13403, 15'd13469, 15'd13562,
    15'd13525, 15'd13558, 15'd13611, 15'd13650, 15'd13664, 15'd13726, 15'd13774,
    15'd13800, 15'd13847, 15'd13926, 15'd13931, 15'd13977, 15'd14000, 15'd14032,
    15'd14072, 15'd14175, 15'd14250, 15'd14325, 15'd14441, 15'd14532, 15'd14615,
    15'd14731, 15'd14897, 15'd14996, 15'd15091, 15'd15151, 15'd15229, 15'd15324,
    15'd15424, 15'd15512, 15'd15570, 15'd15600, 15'd15670, 15'd15815, 15'd15856,
    15'd15938, 15'd16015, 15'd16115, 15'd16188, 15'd16230, 15'd16256, 15'd16328,
    15'd16457, 15'd16569, 15'd16811, 15'd16928, 15'd16959, 15'd17029, 15'd17071,
    15'd17174, 15'd17297, 15'd17344, 15'd17349, 15'd17380, 15'd17438
  };

  localparam logic [PRESS_W-1:0] PRESS_ROM [0:TABLE_ENTRIES-1] = '{
    17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9, 17'd10,
    17'd11, 17'd12, 17'd13, 17'd14, 17'd15, 17'd16, 17'd17, 17'd18, 17'd19, 17'd20,
    17'd21, 17'd22, 17'd23, 17'd24, 17'd25, 17'd26, 17'd27, 17'd28, 17'd29, 17'd30,
    17'd31, 17'd32, 17'd33, 17'd34, 17'd35, 17'd36, 17'd37, 17'd38, 17'd39, 17'd40,
    17'd41, 17'd42, 17'd43, 17'd44, 17'd45, 17'd46, 17'd47, 17'd48, 17'd49, 17'd50,
    17'd51, 17'd52, 17'd53, 17'd54, 17'd55, 17'd56, 17'd57, 17'd58, 17'd59, 17'd60,
    17'd61, 17'd62, 17'd63, 17'd64, 17'd65, 17'd66, 17'd67, 17'd68, 17'd69, 17'd70,
    17'd71, 17'd72, 17'd73, 17'd74, 17'd75, 17'd76, 17'd77, 17'd78, 17'd79, 17'd80,
    17'd81, 17'd82, 17'd83, 17'd84, 17'd85, 17'd86, 17'd87, 17'd88, 17'd89, 17'd90,
    17'd91, 17'd92, 17'd93, 17'd94, 17'd95, 17'd96, 17'd97, 17'd98, 17'd99, 17'd100,
    17'd110, 17'd120, 17'd130, 17'd140, 17'd150, 17'd160, 17'd170, 17'd180, 17'd190,
    17'd200, 17'd210, 17'd220, 17'd230, 17'd240, 17'd250, 17'd260, 17'd270, 17'd280,
    17'd290, 17'd300, 17'd310, 17'd320, 17'd330, 17'd340, 17'd350, 17'd360, 17'd370,
    17'd380, 17'd390, 17'd400, 17'd410, 17'd420, 17'd430, 17'd440, 17'd450, 17'd460,
    17'd470, 17'd480, 17'd490, 17'd500, 17'd510, 17'd520, 17'd530, 17'd540, 17'd550,
    17'd560, 17'd570, 17'd580, 17'd590, 17'd600, 17'd610, 17'd620, 17'd630, 17'd640,
    17'd650, 17'd660, 17'd670, 17'd680, 17'd690, 17'd700, 17'd710, 17'd720, 17'd730,
    17'd740, 17'd750, 17'd760, 17'd770, 17'd780, 17'd790, 17'd800, 17'd810, 17'd820,
    17'd830, 17'd840, 17'd850, 17'd860, 17'd870, 17'd880, 17'd890, 17'd900, 17'd910,
    17'd920, 17'd930, 17'd940, 17'd950, 17'd960, 17'd970, 17'd980, 17'd990, 17'd1000,
    17'd1100, 17'd1200, 17'd1300, 17'd1400, 17'd1500, 17'd1600, 17'd1700, 17'd1800,
    17'd1900, 17'd2000, 17'd2100, 17'd2200, 17'd2300, 17'd2400, 17'd2500, 17'd2600,
    17'd2700, 17'd2800, 17'd2900, 17'd3000, 17'd3600, 17'd3800, 17'd4000, 17'd4800,
    17'd5500, 17'd6000, 17'd7000, 17'd7500, 17'd8500, 17'd9000, 17'd10000, 17'd20000,
    17'd30000, 17'd40000, 17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000,
    17'd100000, 17'd110000
  };

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic                found;
    logic                oor;
    logic [SCALED_W-1:0] scaled;
  } seg_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  rem;
    logic [PRESS_W-1:0] low;
    logic [FREQ_W-1:0]  span;
    logic [PRESS_W-1:0] p0;
    logic               found;
    logic               oor;
  } div_t;

endpackage

// ===== rtl/core/freq_to_pressure_interpolator.sv =====
`timescale 1ns / 1ps
// Gauge frequency to pressure converter.
// Slave stream: one beat carries a raw 20-bit frequency count in tdata.
// The count is scaled by 4/10, looked up in a 231-entry calibration table
// and linearly interpolated inside the first bracketing segment.
// Master stream: one beat per input with the 17-bit pressure in tdata and
// the out-of-range flag in tuser; out-of-range readings give 0x1FFFF.
// The pipeline registers are: scale multiply, table compare, two-level
// priority search, segment fetch, interpolation multiply,
// one quotient bit per stage of a 17-stage divider, and output.
// A new beat is taken every cycle unless the master side stalls; the divider stages set the depth.
// When the master side stalls the whole pipeline holds, and s_axis_tready
// drops until the waiting beat leaves. Reset empties the pipeline and holds
// s_axis_tready low; there is no other state.
`include "freq_to_pressure_interpolator_defines.svh"
module freq_to_pressure_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [19:0] frequency_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [16:0] pressure_value
  output logic [0:0]  m_axis_tuser    // [0] out_of_range
);

  logic                          en;
  logic                          scl_valid;
  logic [ftp_pkg::SCALED_W-1:0]  scaled;
  logic                          seg_valid;
  ftp_pkg::seg_t                 seg;
  logic                          div_valid;
  ftp_pkg::div_t                 div_in;
  logic [ftp_pkg::PRESS_W-1:0]   pressure;
  logic                          oor;

  // advance everything unless the output beat is stuck
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  ftp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .count     (s_axis_tdata[ftp_pkg::COUNT_W-1:0]),
    .out_valid (scl_valid),
    .scaled    (scaled)
  );

  ftp_search u_search (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (scl_valid),
    .scaled    (scaled),
    .out_valid (seg_valid),
    .seg       (seg)
  );

  ftp_segment u_segment (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (seg_valid),
    .seg       (seg),
    .out_valid (div_valid),
    .dout      (div_in)
  );

  ftp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .din       (div_in),
    .out_valid (m_axis_tvalid),
    .pressure  (pressure),
    .oor       (oor)
  );

  assign m_axis_tdata = {7'b0, pressure};
  assign m_axis_tuser = oor;

  `FTP_ASSERT(a_oor_code, (m_axis_tvalid && m_axis_tuser[0]) |-> (pressure == ftp_pkg::OVERLOAD_CODE), "out of range beat without overload code")
  `FTP_ASSERT(a_in_range_max, (m_axis_tvalid && !m_axis_tuser[0]) |-> (pressure <= ftp_pkg::PRESS_ROM[ftp_pkg::TABLE_ENTRIES-1]), "interpolated pressure above table")
  `FTP_ASSERT_NEVER(a_in_range_zero, m_axis_tvalid && !m_axis_tuser[0] && (pressure < ftp_pkg::PRESS_ROM[0]), "interpolated pressure below table")

endmodule

// ===== rtl/core/ftp_scale.sv =====
`timescale 1ns / 1ps
module ftp_scale (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [ftp_pkg::COUNT_W-1:0]        count,
  output logic                               out_valid,
  output logic [ftp_pkg::SCALED_W-1:0]       scaled
);

  logic [ftp_pkg::PROD_W-1:0] prod;

  // floor(2 * count / 5) by reciprocal; exact over the whole input range
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {count, 1'b0} * ftp_pkg::RECIP_MUL;
    end
  end

  assign scaled = prod[ftp_pkg::RECIP_SHIFT +: ftp_pkg::SCALED_W];

endmodule

// ===== rtl/core/ftp_search.sv =====
`timescale 1ns / 1ps
module ftp_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [ftp_pkg::SCALED_W-1:0]  scaled,
  output logic                          out_valid,
  output ftp_pkg::seg_t                 seg
);

  localparam int N = ftp_pkg::TABLE_ENTRIES;
  localparam int NG = ftp_pkg::NUM_GROUPS;
  localparam int GS = ftp_pkg::GROUP_SIZE;

  // stage A: hit per entry
  logic [N-1:0]                  hit_next;
  logic [N-1:0]                  hit;
  logic                          oor_next;
  logic                          oor_a;
  logic [ftp_pkg::SCALED_W-1:0]  scaled_a;
  logic                          vld_a;

  // stage B: first hit inside each group
  logic [NG-1:0]                 grp_any_next;
  logic [ftp_pkg::LOC_W-1:0]     grp_loc_next [NG];
  logic [NG-1:0]                 grp_any;
  logic [ftp_pkg::LOC_W-1:0]     grp_loc [NG];
  logic                          oor_b;
  logic [ftp_pkg::SCALED_W-1:0]  scaled_b;
  logic                          vld_b;

  ftp_pkg::seg_t                 seg_next;

  always_comb begin
    for (int i = 0; i < N - 1; i++) begin
      hit_next[i] = (scaled == ftp_pkg::SCALED_W'(ftp_pkg::FREQ_ROM[i])) ||
                    ((scaled > ftp_pkg::SCALED_W'(ftp_pkg::FREQ_ROM[i])) &&
                     (scaled < ftp_pkg::SCALED_W'(ftp_pkg::FREQ_ROM[i+1])));
    end
    hit_next[N-1] = (scaled == ftp_pkg::SCALED_W'(ftp_pkg::FREQ_ROM[N-1]));
    oor_next = (scaled < ftp_pkg::SCALED_W'(ftp_pkg::FREQ_ROM[0])) ||
               (scaled > ftp_pkg::SCALED_W'(ftp_pkg::FREQ_ROM[N-1]));
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_next[g] = 1'b0;
      grp_loc_next[g] = '0;
      // scan down so the lowest hit wins
      for (int j = GS - 1; j >= 0; j--) begin
        if ((g * GS + j < N) && hit[(g * GS + j) % N]) begin
          grp_any_next[g] = 1'b1;
          grp_loc_next[g] = ftp_pkg::LOC_W'(j);
        end
      end
    end
  end

  always_comb begin
    seg_next.idx    = '0;
    seg_next.found  = 1'b0;
    seg_next.oor    = oor_b;
    seg_next.scaled = scaled_b;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        seg_next.found = 1'b1;
        seg_next.idx   = ftp_pkg::IDX_W'(g * GS) + ftp_pkg::IDX_W'(grp_loc[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      vld_b     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_valid;
      vld_b     <= vld_a;
      out_valid <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit      <= hit_next;
      oor_a    <= oor_next;
      scaled_a <= scaled;
      grp_any  <= grp_any_next;
      grp_loc  <= grp_loc_next;
      oor_b    <= oor_a;
      scaled_b <= scaled_a;
      seg      <= seg_next;
    end
  end

endmodule

// ===== rtl/core/ftp_segment.sv =====
`timescale 1ns / 1ps
module ftp_segment (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  ftp_pkg::seg_t  seg,
  output logic           out_valid,
  output ftp_pkg::div_t  dout
);

  localparam int FW = ftp_pkg::FREQ_W;
  localparam int PW = ftp_pkg::PRESS_W;

  logic [ftp_pkg::IDX_W-1:0] idx_hi;
  logic [FW-1:0]             f0;
  logic [FW-1:0]             f1;
  logic [PW-1:0]             p0;
  logic [PW-1:0]             p1;
  logic                      exact;

  logic [FW-1:0]             df;
  logic [PW-1:0]             dp;
  logic [FW-1:0]             span;
  logic [PW-1:0]             p0_q;
  logic                      found_q;
  logic                      oor_q;
  logic                      vld_d;
  logic [FW+PW-1:0]          prod;

  always_comb begin
    idx_hi = (seg.idx == ftp_pkg::IDX_W'(ftp_pkg::TABLE_ENTRIES - 1)) ? seg.idx
                                                                     : seg.idx + 1'b1;
    f0    = ftp_pkg::FREQ_ROM[seg.idx];
    f1    = ftp_pkg::FREQ_ROM[idx_hi];
    p0    = ftp_pkg::PRESS_ROM[seg.idx];
    p1    = ftp_pkg::PRESS_ROM[idx_hi];
    exact = (seg.scaled == ftp_pkg::SCALED_W'(f0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_d     <= in_valid;
      out_valid <= vld_d;
    end
  end

  // exact hit: zero offset over a unit span leaves p0
  always_ff @(posedge clk) begin
    if (en) begin
      df      <= exact ? '0 : FW'(seg.scaled - ftp_pkg::SCALED_W'(f0));
      dp      <= exact ? '0 : p1 - p0;
      span    <= exact ? FW'(1) : f1 - f0;
      p0_q    <= p0;
      found_q <= seg.found;
      oor_q   <= seg.oor;
    end
  end

  always_comb begin
    prod = (FW+PW)'(df) * (FW+PW)'(dp);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem   <= prod[FW+PW-1:PW];
      dout.low   <= prod[PW-1:0];
      dout.span  <= span;
      dout.p0    <= p0_q;
      dout.found <= found_q;
      dout.oor   <= oor_q;
    end
  end

endmodule

// ===== rtl/core/ftp_div.sv =====
`timescale 1ns / 1ps
module ftp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  ftp_pkg::div_t                din,
  output logic                         out_valid,
  output logic [ftp_pkg::PRESS_W-1:0]  pressure,
  output logic                         oor
);

  localparam int NS = ftp_pkg::DIV_STEPS;
  localparam int FW = ftp_pkg::FREQ_W;
  localparam int PW = ftp_pkg::PRESS_W;

  ftp_pkg::div_t  st [NS];
  logic [NS-1:0]  vld;

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < NS; k++) begin : g_step
    ftp_pkg::div_t  prev;
    ftp_pkg::div_t  nxt;
    logic           prev_v;
    logic [FW:0]    t;
    logic           qb;

    if (k == 0) begin : g_first
      assign prev   = din;
      assign prev_v = in_valid;
    end else begin : g_rest
      assign prev   = st[k-1];
      assign prev_v = vld[k-1];
    end

    always_comb begin
      nxt = prev;
      t   = {prev.rem, prev.low[PW-1]};
      qb  = (t >= {1'b0, prev.span});
      nxt.rem = qb ? FW'(t - {1'b0, prev.span}) : t[FW-1:0];
      nxt.low = {prev.low[PW-2:0], qb};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pressure <= (st[NS-1].oor || !st[NS-1].found) ? ftp_pkg::OVERLOAD_CODE
                                                    : st[NS-1].low + st[NS-1].p0;
      oor      <= st[NS-1].oor;
    end
  end

endmodule
